### hdl/linear_diophantine_solver_defines.svh
// ----------------------------------------------------------------------------
// Linear Diophantine solver - assertion macros
// Shared property shapes for the port checker.
// ----------------------------------------------------------------------------
`ifndef LINEAR_DIOPHANTINE_SOLVER_DEFINES_SVH
`define LINEAR_DIOPHANTINE_SOLVER_DEFINES_SVH

// same-cycle implication, off during reset
`define LDS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("linear_diophantine_solver: check failed");

// next-cycle implication, off during reset
`define LDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("linear_diophantine_solver: check failed");

`endif

### hdl/lds_pkg.sv
// ----------------------------------------------------------------------------
// lds_pkg
// Shared types, microcode word layout and control program of the solver.
// ----------------------------------------------------------------------------
package lds_pkg;

	localparam int DEF_DATA_WIDTH = 32;
	localparam int DEF_MAX_STEPS  = 64;
	localparam int PC_W           = 5;

	// datapath actions
	typedef enum logic [3:0] {
		OP_NONE    = 4'd0,
		OP_LOAD    = 4'd1,
		OP_DIV_AB  = 4'd2,
		OP_SHIFT   = 4'd3,
		OP_MUL_X   = 4'd4,
		OP_ADD_X   = 4'd5,
		OP_ADD_Y   = 4'd6,
		OP_SIGN    = 4'd7,
		OP_SET_BZ  = 4'd8,
		OP_DIV_C   = 4'd9,
		OP_MUL_XK  = 4'd10,
		OP_STORE_X = 4'd11,
		OP_STORE_Y = 4'd12,
		OP_CLEAR   = 4'd13,
		OP_PUBLISH = 4'd14
	} op_t;

	// jump conditions
	typedef enum logic [3:0] {
		C_NEVER    = 4'd0,
		C_ALWAYS   = 4'd1,
		C_NO_IN    = 4'd2,
		C_B_ZERO   = 4'd3,
		C_DIV_BUSY = 4'd4,
		C_REM_ZERO = 4'd5,
		C_REM_NZ   = 4'd6,
		C_I_LAST   = 4'd7,
		C_RA_ZERO  = 4'd8,
		C_OUT_BUSY = 4'd9
	} cond_t;

	typedef logic [PC_W-1:0] pc_t;

	// program addresses
	localparam pc_t S_IDLE  = 5'd0;
	localparam pc_t S_CHK_B = 5'd1;
	localparam pc_t S_DIV   = 5'd2;
	localparam pc_t S_DWAIT = 5'd3;
	localparam pc_t S_SHIFT = 5'd4;
	localparam pc_t S_MULX  = 5'd5;
	localparam pc_t S_ADDX  = 5'd6;
	localparam pc_t S_ADDY  = 5'd7;
	localparam pc_t S_LOOP  = 5'd8;
	localparam pc_t S_ENDC  = 5'd9;
	localparam pc_t S_BZ    = 5'd10;
	localparam pc_t S_DIVC  = 5'd11;
	localparam pc_t S_CWAIT = 5'd12;
	localparam pc_t S_MULXK = 5'd13;
	localparam pc_t S_STX   = 5'd14;
	localparam pc_t S_STY   = 5'd15;
	localparam pc_t S_FAIL  = 5'd16;
	localparam pc_t S_WRITE = 5'd17;
	localparam pc_t S_DONE  = 5'd18;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic b_zero;
		logic ra_zero;
		logic div_busy;
		logic rem_zero;
		logic i_last;
		logic out_busy;
	} stat_t;

	// control store: taken condition jumps to target, else falls through
	function automatic ctrl_t ucode(input pc_t pc);
		ctrl_t w;
		unique case (pc)
			S_IDLE:  w = '{op: OP_LOAD,    cond: C_NO_IN,    target: S_IDLE};
			S_CHK_B: w = '{op: OP_NONE,    cond: C_B_ZERO,   target: S_BZ};
			S_DIV:   w = '{op: OP_DIV_AB,  cond: C_NEVER,    target: S_IDLE};
			S_DWAIT: w = '{op: OP_NONE,    cond: C_DIV_BUSY, target: S_DWAIT};
			S_SHIFT: w = '{op: OP_SHIFT,   cond: C_REM_ZERO, target: S_ENDC};
			S_MULX:  w = '{op: OP_MUL_X,   cond: C_NEVER,    target: S_IDLE};
			S_ADDX:  w = '{op: OP_ADD_X,   cond: C_NEVER,    target: S_IDLE};
			S_ADDY:  w = '{op: OP_ADD_Y,   cond: C_I_LAST,   target: S_FAIL};
			S_LOOP:  w = '{op: OP_NONE,    cond: C_ALWAYS,   target: S_DIV};
			S_ENDC:  w = '{op: OP_SIGN,    cond: C_ALWAYS,   target: S_DIVC};
			S_BZ:    w = '{op: OP_SET_BZ,  cond: C_RA_ZERO,  target: S_FAIL};
			S_DIVC:  w = '{op: OP_DIV_C,   cond: C_NEVER,    target: S_IDLE};
			S_CWAIT: w = '{op: OP_NONE,    cond: C_DIV_BUSY, target: S_CWAIT};
			S_MULXK: w = '{op: OP_MUL_XK,  cond: C_REM_NZ,   target: S_FAIL};
			S_STX:   w = '{op: OP_STORE_X, cond: C_NEVER,    target: S_IDLE};
			S_STY:   w = '{op: OP_STORE_Y, cond: C_ALWAYS,   target: S_WRITE};
			S_FAIL:  w = '{op: OP_CLEAR,   cond: C_NEVER,    target: S_IDLE};
			S_WRITE: w = '{op: OP_PUBLISH, cond: C_OUT_BUSY, target: S_WRITE};
			S_DONE:  w = '{op: OP_NONE,    cond: C_ALWAYS,   target: S_IDLE};
			default: w = '{op: OP_NONE,    cond: C_ALWAYS,   target: S_IDLE};
		endcase
		return w;
	endfunction

endpackage

### hdl/lds_div.sv
// ----------------------------------------------------------------------------
// lds_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lds_div #(
	parameter int DATA_WIDTH = lds_pkg::DEF_DATA_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DATA_WIDTH-1:0] dividend,
	input  logic [DATA_WIDTH-1:0] divisor,
	output logic                  busy,
	output logic [DATA_WIDTH-1:0] quot,
	output logic [DATA_WIDTH-1:0] rem
);

	localparam int CW = $clog2(DATA_WIDTH + 1);

	logic [CW-1:0]         cnt_q;
	logic                  busy_q;
	logic [DATA_WIDTH-1:0] quot_q;
	logic [DATA_WIDTH-1:0] rem_q;
	logic [DATA_WIDTH-1:0] dvs_q;
	logic [DATA_WIDTH:0]   trial;
	logic [DATA_WIDTH:0]   diff;

	assign trial = {rem_q, quot_q[DATA_WIDTH-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(DATA_WIDTH);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= (cnt_q != CW'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			if (!diff[DATA_WIDTH]) begin
				rem_q  <= diff[DATA_WIDTH-1:0];
				quot_q <= {quot_q[DATA_WIDTH-2:0], 1'b1};
			end else begin
				rem_q  <= trial[DATA_WIDTH-1:0];
				quot_q <= {quot_q[DATA_WIDTH-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

### hdl/lds_seq.sv
// ----------------------------------------------------------------------------
// lds_seq
// Step counter and control store; picks the next step from a status flag.
// ----------------------------------------------------------------------------
module lds_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  lds_pkg::stat_t  stat,
	output lds_pkg::ctrl_t  ctrl
);

	lds_pkg::pc_t pc_q;
	lds_pkg::ctrl_t word;
	logic take;

	always_comb word = lds_pkg::ucode(pc_q);

	always_comb begin
		unique case (word.cond)
			lds_pkg::C_NEVER:    take = 1'b0;
			lds_pkg::C_ALWAYS:   take = 1'b1;
			lds_pkg::C_NO_IN:    take = !stat.in_valid;
			lds_pkg::C_B_ZERO:   take = stat.b_zero;
			lds_pkg::C_DIV_BUSY: take = stat.div_busy;
			lds_pkg::C_REM_ZERO: take = stat.rem_zero;
			lds_pkg::C_REM_NZ:   take = !stat.rem_zero;
			lds_pkg::C_I_LAST:   take = stat.i_last;
			lds_pkg::C_RA_ZERO:  take = stat.ra_zero;
			lds_pkg::C_OUT_BUSY: take = stat.out_busy;
			default:             take = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= lds_pkg::S_IDLE;
		end else if (take) begin
			pc_q <= word.target;
		end else begin
			pc_q <= pc_q + 1'b1;
		end
	end

	assign ctrl = word;

endmodule

### hdl/lds_dp.sv
// ----------------------------------------------------------------------------
// lds_dp
// Remainder pair, convergents, shared multiplier and divider, result and
// output registers, all driven by the microcode action field.
// ----------------------------------------------------------------------------
module lds_dp #(
	parameter int DATA_WIDTH = lds_pkg::DEF_DATA_WIDTH,
	parameter int MAX_STEPS  = lds_pkg::DEF_MAX_STEPS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lds_pkg::ctrl_t      ctrl,
	output lds_pkg::stat_t      stat,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [30:0]         coef_a,
	input  logic [30:0]         coef_b,
	input  logic signed [31:0]  rhs_c,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [63:0]  x_solution,
	output logic signed [63:0]  y_solution,
	output logic [30:0]         common_divisor,
	output logic                solvable
);

	localparam int DW = DATA_WIDTH;
	localparam int SW = $clog2(MAX_STEPS);

	logic [DW-2:0]   ra_q, rb_q;
	logic [DW-1:0]   xp_q, xc_q, yp_q, yc_q;
	logic [SW-1:0]   i_q;
	logic            cneg_q, xneg_q, ok_q;
	logic [DW-1:0]   cmag_q;
	logic [2*DW-1:0] prod_q;
	logic [63:0]     xres_q, yres_q;
	logic            out_valid_q;
	logic [63:0]     xout_q, yout_q;
	logic [30:0]     gout_q;
	logic            sout_q;

	logic [DW-1:0]   c_low, c_mag;
	logic            div_start, div_busy;
	logic [DW-1:0]   div_dvd, div_dvs, div_quot, div_rem;
	logic [DW-1:0]   mul_a;
	logic            mul_en, out_busy, load, publish;
	logic [63:0]     mag64;

	assign c_low = rhs_c[DW-1:0];
	assign c_mag = c_low[DW-1] ? (~c_low + 1'b1) : c_low;

	assign out_busy = out_valid_q && !out_ready;
	assign load     = (ctrl.op == lds_pkg::OP_LOAD) && in_valid;
	assign publish  = (ctrl.op == lds_pkg::OP_PUBLISH) && !out_busy;
	assign in_ready = (ctrl.op == lds_pkg::OP_LOAD);

	// divider: chain step ra/rb, or |c|/gcd during scaling
	assign div_start = (ctrl.op == lds_pkg::OP_DIV_AB) || (ctrl.op == lds_pkg::OP_DIV_C);
	assign div_dvd   = (ctrl.op == lds_pkg::OP_DIV_C) ? cmag_q : {1'b0, ra_q};
	assign div_dvs   = (ctrl.op == lds_pkg::OP_DIV_C) ? {1'b0, ra_q} : {1'b0, rb_q};

	lds_div #(.DATA_WIDTH(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// one multiplier: quotient times x-side, then y-side on the next step
	assign mul_a  = ((ctrl.op == lds_pkg::OP_MUL_X) || (ctrl.op == lds_pkg::OP_MUL_XK)) ?
		xc_q : yc_q;
	assign mul_en = (ctrl.op == lds_pkg::OP_MUL_X) || (ctrl.op == lds_pkg::OP_ADD_X) ||
		(ctrl.op == lds_pkg::OP_MUL_XK) || (ctrl.op == lds_pkg::OP_STORE_X);
	assign mag64  = 64'(prod_q);

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= mul_a * div_quot;
		end
		case (ctrl.op)
			lds_pkg::OP_LOAD: begin
				if (load) begin
					ra_q   <= coef_a[DW-2:0];
					rb_q   <= coef_b[DW-2:0];
					cneg_q <= c_low[DW-1];
					cmag_q <= c_mag;
					xp_q   <= DW'(1);
					yp_q   <= '0;
					xc_q   <= '0;
					yc_q   <= DW'(1);
					i_q    <= '0;
				end
			end
			lds_pkg::OP_SHIFT: begin
				ra_q <= rb_q;
				rb_q <= div_rem[DW-2:0];
			end
			lds_pkg::OP_ADD_X: begin
				xp_q <= xc_q;
				xc_q <= prod_q[DW-1:0] + xp_q;
			end
			lds_pkg::OP_ADD_Y: begin
				yp_q <= yc_q;
				yc_q <= prod_q[DW-1:0] + yp_q;
				i_q  <= i_q + 1'b1;
			end
			lds_pkg::OP_SIGN: begin
				// x is negative for an even final step index
				xneg_q <= !i_q[0];
			end
			lds_pkg::OP_SET_BZ: begin
				xc_q   <= DW'(1);
				yc_q   <= '0;
				xneg_q <= 1'b0;
			end
			lds_pkg::OP_STORE_X: begin
				xres_q <= (xneg_q ^ cneg_q) ? (~mag64 + 1'b1) : mag64;
			end
			lds_pkg::OP_STORE_Y: begin
				yres_q <= (!xneg_q ^ cneg_q) ? (~mag64 + 1'b1) : mag64;
				ok_q   <= 1'b1;
			end
			lds_pkg::OP_CLEAR: begin
				xres_q <= '0;
				yres_q <= '0;
				ok_q   <= 1'b0;
			end
			default: begin
			end
		endcase
		if (publish) begin
			xout_q <= xres_q;
			yout_q <= yres_q;
			gout_q <= 31'(ra_q);
			sout_q <= ok_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (publish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.in_valid = in_valid;
	assign stat.b_zero   = (rb_q == '0);
	assign stat.ra_zero  = (ra_q == '0);
	assign stat.div_busy = div_busy;
	assign stat.rem_zero = (div_rem == '0);
	assign stat.i_last   = (i_q == SW'(MAX_STEPS - 1));
	assign stat.out_busy = out_busy;

	assign out_valid      = out_valid_q;
	assign x_solution     = xout_q;
	assign y_solution     = yout_q;
	assign common_divisor = gout_q;
	assign solvable       = sout_q;

endmodule

### hdl/linear_diophantine_solver.sv
// Each Euclid division step runs on the bit-serial divider.
// Throughput: one item at a time; the next input beat is taken in S_IDLE, entered via
//   S_DONE once the result is published, while a finished result may still wait at the output.
// Reset (arst_n low) clears the step counter, divider and output valid at once.
// ----------------------------------------------------------------------------
// linear_diophantine_solver
// Extended Euclid solver for a*x + b*y = c under a microcoded sequencer.
// ----------------------------------------------------------------------------
module linear_diophantine_solver #(
	parameter int DATA_WIDTH = lds_pkg::DEF_DATA_WIDTH,
	parameter int MAX_STEPS  = lds_pkg::DEF_MAX_STEPS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [30:0]         coef_a,
	input  logic [30:0]         coef_b,
	input  logic signed [31:0]  rhs_c,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [63:0]  x_solution,
	output logic signed [63:0]  y_solution,
	output logic [30:0]         common_divisor,
	output logic                solvable
);

	lds_pkg::ctrl_t ctrl;
	lds_pkg::stat_t stat;

	lds_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	lds_dp #(
		.DATA_WIDTH (DATA_WIDTH),
		.MAX_STEPS  (MAX_STEPS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.stat           (stat),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.coef_a         (coef_a),
		.coef_b         (coef_b),
		.rhs_c          (rhs_c),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.x_solution     (x_solution),
		.y_solution     (y_solution),
		.common_divisor (common_divisor),
		.solvable       (solvable)
	);

endmodule

### hdl/lds_chk.sv
// ----------------------------------------------------------------------------
// lds_chk
// Port-level checks of the solver, bound to the top level.
// ----------------------------------------------------------------------------
`include "linear_diophantine_solver_defines.svh"

module lds_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [63:0] x_solution,
	input logic signed [63:0] y_solution,
	input logic [30:0]        common_divisor,
	input logic               solvable
);

	// a stalled result beat holds
	`LDS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(x_solution) && $stable(y_solution) && $stable(common_divisor) && $stable(solvable))

	// no solution means both coefficients read zero
	`LDS_ASSERT_NOW(a_unsolv_zero, clk, arst_n, out_valid && !solvable, x_solution == 64'sd0 && y_solution == 64'sd0)

	// a solvable result carries a nonzero gcd
	`LDS_ASSERT_NOW(a_solv_gcd, clk, arst_n, out_valid && solvable, common_divisor != 31'd0)

	// the block works on one item at a time
	`LDS_ASSERT_NEXT(a_one_item, clk, arst_n, in_valid && in_ready, !in_ready)

endmodule

bind linear_diophantine_solver lds_chk u_lds_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.x_solution     (x_solution),
	.y_solution     (y_solution),
	.common_divisor (common_divisor),
	.solvable       (solvable)
);
